@@ rtl/hsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the slope and aspect core
package hsa_pkg;

  localparam int MAX_COLS     = 4096;
  localparam int COL_W        = $clog2(MAX_COLS);
  localparam int CNT_W        = COL_W + 1;
  localparam int ROW_W        = 16;
  localparam int LEN_W        = 13;
  localparam int SIZE_W       = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int ELEV_W       = 24;
  localparam int GRAD_W       = ELEV_W + 3;
  localparam int SQ_W         = 2 * GRAD_W;
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = RAD_W / 2;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int CV_W         = 56;
  localparam int Z_W          = 32;
  localparam int SLOPE_W      = 13;
  localparam int ASPECT_W     = 15;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic signed [Z_W-1:0] QUARTER_Q  = Z_W'(5760 * 65536);
  localparam logic signed [Z_W-1:0] HALF_LSB   = Z_W'(32768);
  localparam logic [ASPECT_W-1:0]   TURN_UNITS = ASPECT_W'(23040);
  localparam logic [SLOPE_W-1:0]    SLOPE_MAX  = SLOPE_W'(5760);

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH = 2'd0,
    CFG_ROW_COUNT  = 2'd1,
    CFG_CELL_SIZE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [LEN_W-1:0]  row_length;
    logic [ROW_W-1:0]  row_count;
    logic [SIZE_W-1:0] spacing;
  } cfg_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic                     last;
    logic                     eof;
  } job_t;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_RD_SAMP,
    FS_WIN,
    FS_JOB1,
    FS_JOB2,
    FS_RD_W,
    FS_RD_C,
    FS_RD_E,
    FS_RD_LAST,
    FS_JOB_DRAIN
  } front_state_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SQ_X,
    BS_SQ_Y,
    BS_ROOT,
    BS_SLOPE,
    BS_ASPECT,
    BS_FIN
  } back_state_e;

  // (a + 2b + c) - (d + 2e + f)
  function automatic logic signed [GRAD_W-1:0] horn_diff(
    input logic signed [ELEV_W-1:0] a,
    input logic signed [ELEV_W-1:0] b,
    input logic signed [ELEV_W-1:0] c,
    input logic signed [ELEV_W-1:0] d,
    input logic signed [ELEV_W-1:0] e,
    input logic signed [ELEV_W-1:0] f
  );
    logic signed [GRAD_W-1:0] pos;
    logic signed [GRAD_W-1:0] neg;
    pos = GRAD_W'(a) + (GRAD_W'(b) <<< 1) + GRAD_W'(c);
    neg = GRAD_W'(d) + (GRAD_W'(e) <<< 1) + GRAD_W'(f);
    return pos - neg;
  endfunction

  // arctan(2^-i) in 2^-16 of 1/64 degree
  function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:  v = Z_W'(188743680);
      5'd1:  v = Z_W'(111421900);
      5'd2:  v = Z_W'(58872272);
      5'd3:  v = Z_W'(29884485);
      5'd4:  v = Z_W'(15000234);
      5'd5:  v = Z_W'(7507429);
      5'd6:  v = Z_W'(3754631);
      5'd7:  v = Z_W'(1877430);
      5'd8:  v = Z_W'(938729);
      5'd9:  v = Z_W'(469366);
      5'd10: v = Z_W'(234683);
      5'd11: v = Z_W'(117342);
      5'd12: v = Z_W'(58671);
      5'd13: v = Z_W'(29335);
      5'd14: v = Z_W'(14668);
      5'd15: v = Z_W'(7334);
      5'd16: v = Z_W'(3667);
      5'd17: v = Z_W'(1833);
      5'd18: v = Z_W'(917);
      5'd19: v = Z_W'(458);
      5'd20: v = Z_W'(229);
      5'd21: v = Z_W'(115);
      5'd22: v = Z_W'(57);
      5'd23: v = Z_W'(29);
      5'd24: v = Z_W'(14);
      5'd25: v = Z_W'(7);
      5'd26: v = Z_W'(4);
      5'd27: v = Z_W'(2);
      5'd28: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/horn_slope_aspect_core.sv @@
`timescale 1ns / 1ps
// Top level: Horn 3x3 slope and aspect over a raster elevation stream
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o | req_type_i, elevation_i
//  out     | out_valid_o/out_stall_i | slope_o, aspect_o, flat_o, cell_col_o,
//          |                         | cell_row_o, last_of_item_o, end_of_frame_o
//  cfg     | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// The front end takes no new item until the last one's jobs are queued; a
// drain tick reads three columns in turn through the single read port of each
// line store RAM. A non-flat cell goes through the back end states in turn
// (shared multiplier, two-bit square root step, one rotation a cycle); flat
// cells skip to the output state. The back end sets the sustained rate.
// A four-entry job queue lets the front end run ahead while results stall.
// Reset clears control state, the window and the counters; line stores are
// not cleared and no result depends on an entry that was never written.
module horn_slope_aspect_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hsa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hsa_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic signed [hsa_pkg::ELEV_W-1:0]  elevation_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hsa_pkg::SLOPE_W-1:0]        slope_o,
  output logic [hsa_pkg::ASPECT_W-1:0]       aspect_o,
  output logic                               flat_o,
  output logic [hsa_pkg::COL_W-1:0]          cell_col_o,
  output logic [hsa_pkg::ROW_W-1:0]          cell_row_o,
  output logic                               last_of_item_o,
  output logic                               end_of_frame_o
);
  import hsa_pkg::*;

  cfg_t cfg_q;
  logic restart;
  job_t push_job;
  job_t pop_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign restart = cfg_we_i && ((cfg_index_i == CFG_ROW_LENGTH) ||
                                (cfg_index_i == CFG_ROW_COUNT) ||
                                (cfg_index_i == CFG_CELL_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_length <= LEN_W'(2);
      cfg_q.row_count  <= ROW_W'(2);
      cfg_q.spacing    <= SIZE_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROW_LENGTH: cfg_q.row_length <= cfg_wdata_i[LEN_W-1:0];
        CFG_ROW_COUNT:  cfg_q.row_count  <= cfg_wdata_i[ROW_W-1:0];
        CFG_CELL_SIZE:  cfg_q.spacing    <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  hsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .restart_i   (restart),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .elevation_i (elevation_i),
    .job_o       (push_job),
    .push_o      (push),
    .full_i      (full)
  );

  hsa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .full_o      (full),
    .empty_o     (empty)
  );

  hsa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .spacing_i      (cfg_q.spacing),
    .job_i          (pop_job),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .slope_o        (slope_o),
    .aspect_o       (aspect_o),
    .flat_o         (flat_o),
    .cell_col_o     (cell_col_o),
    .cell_row_o     (cell_row_o),
    .last_of_item_o (last_of_item_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

@@ rtl/hsa_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port RAM with registered read
module hsa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hsa_fifo.sv @@
`timescale 1ns / 1ps
// Short job queue between the window front end and the angle back end
module hsa_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hsa_pkg::job_t push_data_i,
  input  logic          pop_i,
  output hsa_pkg::job_t pop_data_o,
  output logic          full_o,
  output logic          empty_o
);
  import hsa_pkg::*;

  job_t               data_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q;
  logic [FIFO_AW-1:0] rptr_q;
  logic [FIFO_AW:0]   count_q;

  function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = data_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("job popped from an empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

@@ rtl/hsa_front.sv @@
`timescale 1ns / 1ps
// Front end: raster counters, line stores, 3x3 window and gradient jobs
module hsa_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hsa_pkg::cfg_t                      cfg_i,
  input  logic                               restart_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic signed [hsa_pkg::ELEV_W-1:0]  elevation_i,
  output hsa_pkg::job_t                      job_o,
  output logic                               push_o,
  input  logic                               full_i
);
  import hsa_pkg::*;

  front_state_e state_q, state_d;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] cur_c_q;
  logic [ROW_W-1:0] cur_r_q;
  logic signed [ELEV_W-1:0] v_q;
  logic signed [ELEV_W-1:0] win_q [3][3];
  logic signed [ELEV_W-1:0] da_q [3];
  logic signed [ELEV_W-1:0] db_q [3];

  logic [CNT_W-1:0] cols;
  logic [ROW_W-1:0] rows;
  logic [COL_W-1:0] col_end;
  logic [COL_W-1:0] c_cl;
  logic [CNT_W-1:0] c_inc;
  logic             c_wrap;
  logic             acc_samp;
  logic             acc_drain;
  logic             need1;
  logic             need2;
  logic [COL_W-1:0] cw;
  logic [COL_W-1:0] ce;
  logic [COL_W-1:0] raddr;
  logic             ram_we;
  logic [ELEV_W-1:0] rd_a;
  logic [ELEV_W-1:0] rd_b;

  logic signed [ELEV_W-1:0] t0, t1, t2;
  logic signed [ELEV_W-1:0] nw, n, ne, w, e, sw, s, se;
  logic                     top_sel;
  logic                     west_sel;

  // frame geometry in use
  always_comb begin
    if (cfg_i.row_length < LEN_W'(2)) begin
      cols = CNT_W'(2);
    end else if (int'(cfg_i.row_length) > MAX_COLS) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = CNT_W'(cfg_i.row_length);
    end
    rows = (cfg_i.row_count < ROW_W'(2)) ? ROW_W'(2) : cfg_i.row_count;
  end

  assign col_end   = COL_W'(cols - 1'b1);
  assign c_cl      = (CNT_W'(col_q) >= cols) ? col_end : col_q;
  assign c_inc     = CNT_W'(c_cl) + 1'b1;
  assign c_wrap    = (c_inc >= cols);
  assign acc_samp  = (state_q == FS_IDLE) && in_valid_i && (req_type_i == REQ_SAMPLE)
                     && (row_q < rows);
  assign acc_drain = (state_q == FS_IDLE) && in_valid_i && (req_type_i == REQ_DRAIN)
                     && (row_q >= rows);

  assign need1 = (cur_r_q != '0) && (cur_c_q != '0);
  assign need2 = (cur_r_q != '0) && (cur_c_q == col_end);
  assign cw    = (cur_c_q == '0) ? '0 : cur_c_q - 1'b1;
  assign ce    = ((CNT_W'(cur_c_q) + 1'b1) >= cols) ? cur_c_q : cur_c_q + 1'b1;

  hsa_ram #(.WIDTH(ELEV_W), .DEPTH(MAX_COLS)) u_line_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_c_q),
    .wdata_i (rd_b),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  hsa_ram #(.WIDTH(ELEV_W), .DEPTH(MAX_COLS)) u_line_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_c_q),
    .wdata_i (v_q),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    push_o     = 1'b0;
    ram_we     = 1'b0;
    raddr      = cur_c_q;
    case (state_q)
      FS_IDLE: begin
        in_stall_o = 1'b0;
        if (acc_samp) begin
          state_d = FS_RD_SAMP;
        end else if (acc_drain) begin
          state_d = FS_RD_W;
        end
      end
      FS_RD_SAMP: state_d = FS_WIN;
      FS_WIN: begin
        ram_we  = 1'b1;
        state_d = FS_JOB1;
      end
      FS_JOB1: begin
        if (!need1) begin
          state_d = FS_JOB2;
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = FS_JOB2;
        end
      end
      FS_JOB2: begin
        if (!need2) begin
          state_d = FS_IDLE;
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = FS_IDLE;
        end
      end
      FS_RD_W: begin
        raddr   = cw;
        state_d = FS_RD_C;
      end
      FS_RD_C: state_d = FS_RD_E;
      FS_RD_E: begin
        raddr   = ce;
        state_d = FS_RD_LAST;
      end
      FS_RD_LAST: state_d = FS_JOB_DRAIN;
      FS_JOB_DRAIN: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  // counters advance as the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_samp) begin
      col_q <= c_wrap ? '0 : COL_W'(c_inc);
      if (c_wrap) begin
        row_q <= row_q + 1'b1;
      end
    end else if (acc_drain) begin
      col_q <= c_wrap ? '0 : COL_W'(c_inc);
      if (c_wrap) begin
        row_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else if (state_q == FS_WIN) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= $signed(rd_a);
      win_q[1][2] <= $signed(rd_b);
      win_q[2][2] <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_samp || acc_drain) begin
      cur_c_q <= c_cl;
      cur_r_q <= row_q;
      v_q     <= elevation_i;
    end
    if (state_q == FS_RD_C) begin
      da_q[0] <= $signed(rd_a);
      db_q[0] <= $signed(rd_b);
    end
    if (state_q == FS_RD_E) begin
      da_q[1] <= $signed(rd_a);
      db_q[1] <= $signed(rd_b);
    end
    if (state_q == FS_RD_LAST) begin
      da_q[2] <= $signed(rd_a);
      db_q[2] <= $signed(rd_b);
    end
  end

  // neighbourhood, with edge rows and columns repeated outward
  assign top_sel  = (cur_r_q == ROW_W'(1));
  assign west_sel = (cur_c_q == COL_W'(1));
  assign t0 = top_sel ? win_q[1][0] : win_q[0][0];
  assign t1 = top_sel ? win_q[1][1] : win_q[0][1];
  assign t2 = top_sel ? win_q[1][2] : win_q[0][2];

  always_comb begin
    case (state_q)
      FS_JOB_DRAIN: begin
        nw = da_q[0]; n = da_q[1]; ne = da_q[2];
        w  = db_q[0]; e = db_q[2];
        sw = db_q[0]; s = db_q[1]; se = db_q[2];
      end
      FS_JOB2: begin
        nw = t1;          n = t2;          ne = t2;
        w  = win_q[1][1]; e = win_q[1][2];
        sw = win_q[2][1]; s = win_q[2][2]; se = win_q[2][2];
      end
      default: begin
        nw = west_sel ? t1 : t0;
        n  = t1;
        ne = t2;
        w  = west_sel ? win_q[1][1] : win_q[1][0];
        e  = win_q[1][2];
        sw = west_sel ? win_q[2][1] : win_q[2][0];
        s  = win_q[2][1];
        se = win_q[2][2];
      end
    endcase
  end

  always_comb begin
    job_o.gx   = horn_diff(ne, e, se, nw, w, sw);
    job_o.gy   = horn_diff(nw, n, ne, sw, s, se);
    job_o.col  = (state_q == FS_JOB1) ? cur_c_q - 1'b1 : cur_c_q;
    job_o.row  = (state_q == FS_JOB_DRAIN) ? rows - 1'b1 : cur_r_q - 1'b1;
    job_o.last = (state_q == FS_JOB1) ? !need2 : 1'b1;
    job_o.eof  = (state_q == FS_JOB_DRAIN) && (cur_c_q == col_end);
  end

endmodule

@@ rtl/hsa_back.sv @@
`timescale 1ns / 1ps
// Back end: gradient magnitude, slope and aspect angles, output register
module hsa_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [hsa_pkg::SIZE_W-1:0]      spacing_i,
  input  hsa_pkg::job_t                   job_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hsa_pkg::SLOPE_W-1:0]     slope_o,
  output logic [hsa_pkg::ASPECT_W-1:0]    aspect_o,
  output logic                            flat_o,
  output logic [hsa_pkg::COL_W-1:0]       cell_col_o,
  output logic [hsa_pkg::ROW_W-1:0]       cell_row_o,
  output logic                            last_of_item_o,
  output logic                            end_of_frame_o
);
  import hsa_pkg::*;

  back_state_e state_q, state_d;

  logic [GRAD_W-1:0]      ax_q, ay_q;
  logic                   east_q, north_q, flat_q;
  logic [COL_W-1:0]       col_q;
  logic [ROW_W-1:0]       row_q;
  logic                   last_q, eof_q;
  logic [SQ_W-1:0]        acc_q;
  logic [RAD_W-1:0]       rem_q, root_q, bit_q;
  logic signed [CV_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0]  z_q, zs_q, za_q;
  logic [STEP_W-1:0]      i_q;

  logic                   out_valid_q;
  logic [SLOPE_W-1:0]     slope_q;
  logic [ASPECT_W-1:0]    aspect_q;
  logic                   flat_out_q;
  logic [COL_W-1:0]       col_out_q;
  logic [ROW_W-1:0]       row_out_q;
  logic                   last_out_q, eof_out_q;

  logic [GRAD_W-1:0]      ax_in, ay_in;
  logic [GRAD_W-1:0]      mul_in;
  logic [SQ_W-1:0]        sq;
  logic [RAD_W:0]         trial;
  logic                   take;
  logic [RAD_W-1:0]       rem_d, root_d;
  logic signed [CV_W-1:0] dx, dy, x_d, y_d;
  logic signed [Z_W-1:0]  ang, z_d, z_cl;
  logic                   last_step;
  logic                   out_free;
  logic [SIZE_W-1:0]      cs_eff;
  logic signed [Z_W-1:0]  slope_sum, b, asp_sum;
  logic [ASPECT_W-1:0]    asp_raw;
  logic [SLOPE_W-1:0]     slope_v;
  logic [ASPECT_W-1:0]    aspect_v;

  assign ax_in  = job_i.gx[GRAD_W-1] ? GRAD_W'(-job_i.gx) : GRAD_W'(job_i.gx);
  assign ay_in  = job_i.gy[GRAD_W-1] ? GRAD_W'(-job_i.gy) : GRAD_W'(job_i.gy);
  assign mul_in = (state_q == BS_SQ_X) ? ax_q : ay_q;
  assign sq     = SQ_W'(mul_in) * SQ_W'(mul_in);
  assign cs_eff = (spacing_i == '0) ? SIZE_W'(1) : spacing_i;

  // one restoring square-root step: two radicand bits per cycle
  assign trial  = (RAD_W + 1)'(root_q) + (RAD_W + 1)'(bit_q);
  assign take   = ((RAD_W + 1)'(rem_q) >= trial);
  assign rem_d  = take ? rem_q - trial[RAD_W-1:0] : rem_q;
  assign root_d = take ? (root_q >> 1) + bit_q : (root_q >> 1);

  // one vectoring rotation per cycle
  assign dx        = y_q >>> i_q;
  assign dy        = x_q >>> i_q;
  assign ang       = $signed(atan_entry(5'(i_q)));
  assign last_step = (i_q == STEP_W'(CORDIC_STEPS - 1));

  always_comb begin
    if (y_q > 0) begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + ang;
    end else begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - ang;
    end
    if (z_d < 0) begin
      z_cl = '0;
    end else if (z_d > QUARTER_Q) begin
      z_cl = QUARTER_Q;
    end else begin
      z_cl = z_d;
    end
  end

  // fold the first quadrant angle onto the compass
  always_comb begin
    slope_sum = zs_q + HALF_LSB;
    slope_v   = SLOPE_W'(slope_sum >>> 16);
    if (east_q && north_q) begin
      b = za_q;
    end else if (east_q) begin
      b = (QUARTER_Q <<< 1) - za_q;
    end else if (!north_q) begin
      b = (QUARTER_Q <<< 1) + za_q;
    end else begin
      b = (QUARTER_Q <<< 2) - za_q;
    end
    asp_sum  = b + HALF_LSB;
    asp_raw  = ASPECT_W'(asp_sum >>> 16);
    aspect_v = (asp_raw >= TURN_UNITS) ? asp_raw - TURN_UNITS : asp_raw;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      BS_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = ((job_i.gx == '0) && (job_i.gy == '0)) ? BS_FIN : BS_SQ_X;
        end
      end
      BS_SQ_X: state_d = BS_SQ_Y;
      BS_SQ_Y: state_d = BS_ROOT;
      BS_ROOT: begin
        if (bit_q == RAD_W'(1)) begin
          state_d = BS_SLOPE;
        end
      end
      BS_SLOPE: begin
        if (last_step) begin
          state_d = BS_ASPECT;
        end
      end
      BS_ASPECT: begin
        if (last_step) begin
          state_d = BS_FIN;
        end
      end
      BS_FIN: begin
        if (out_free) begin
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BS_IDLE: begin
        if (pop_o) begin
          ax_q    <= ax_in;
          ay_q    <= ay_in;
          east_q  <= job_i.gx[GRAD_W-1] || (job_i.gx == '0);
          north_q <= job_i.gy[GRAD_W-1] || (job_i.gy == '0);
          flat_q  <= (job_i.gx == '0) && (job_i.gy == '0);
          col_q   <= job_i.col;
          row_q   <= job_i.row;
          last_q  <= job_i.last;
          eof_q   <= job_i.eof;
        end
      end
      BS_SQ_X: acc_q <= sq;
      BS_SQ_Y: begin
        rem_q  <= (RAD_W'(acc_q) + RAD_W'(sq)) << 10;
        root_q <= '0;
        bit_q  <= RAD_W'(1) << (RAD_W - 2);
      end
      BS_ROOT: begin
        rem_q  <= rem_d;
        root_q <= root_d;
        bit_q  <= bit_q >> 2;
        if (bit_q == RAD_W'(1)) begin
          x_q <= CV_W'(cs_eff) <<< 28;
          y_q <= CV_W'(root_d[ROOT_W-1:0]) <<< 20;
          z_q <= '0;
          i_q <= '0;
        end
      end
      BS_SLOPE: begin
        if (last_step) begin
          zs_q <= z_cl;
          x_q  <= CV_W'(ay_q) <<< 24;
          y_q  <= CV_W'(ax_q) <<< 24;
          z_q  <= '0;
          i_q  <= '0;
        end else begin
          x_q <= x_d;
          y_q <= y_d;
          z_q <= z_d;
          i_q <= i_q + 1'b1;
        end
      end
      BS_ASPECT: begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
        i_q <= i_q + 1'b1;
        if (last_step) begin
          za_q <= z_cl;
        end
      end
      default: ;
    endcase
  end

  // output register: hold until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == BS_FIN) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == BS_FIN) && out_free) begin
      slope_q    <= flat_q ? '0 : slope_v;
      aspect_q   <= flat_q ? '0 : aspect_v;
      flat_out_q <= flat_q;
      col_out_q  <= col_q;
      row_out_q  <= row_q;
      last_out_q <= last_q;
      eof_out_q  <= eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slope_o        = slope_q;
  assign aspect_o       = aspect_q;
  assign flat_o         = flat_out_q;
  assign cell_col_o     = col_out_q;
  assign cell_row_o     = row_out_q;
  assign last_of_item_o = last_out_q;
  assign end_of_frame_o = eof_out_q;

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && flat_out_q) |-> ((slope_q == '0) && (aspect_q == '0)))
    else $error("flat result with nonzero angle");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((slope_q <= SLOPE_MAX) && (aspect_q < TURN_UNITS)))
    else $error("angle out of range");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(slope_q) && $stable(aspect_q)))
    else $error("pending result overwritten");

endmodule
